// ----- hdl/mandelbrot_pixel_iterator_assert.svh -----
// Assertion helpers shared by the iterator RTL.
`ifndef MANDELBROT_PIXEL_ITERATOR_ASSERT_SVH
`define MANDELBROT_PIXEL_ITERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- hdl/mbp_pkg.sv -----
package mbp_pkg;

   // Width of the linear frame buffer address.
   localparam int AddrWidth = 19;
   // Width of the color and of the count output.
   localparam int ColorWidth = 16;
   localparam int CountOutWidth = 4;
   // Configuration data is as wide as the widest register.
   localparam int CsrDataWidth = 4;
   // Number of palette entries in indexed color mode.
   localparam int PaletteSize = 15;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_INDEXED_COLORS = 1'b0,
      CSR_COLOR_SHIFT    = 1'b1
   } csr_index_type;

   // Control travelling with each item along the cell chain.
   typedef struct packed {
      logic valid;
      logic done;
   } mbp_ctl_type;

   // Remainder modulo 15 of an 8-bit count. Since 16 is 1 modulo 15, the sum
   // of the two nibbles has the same remainder and needs at most two subtracts.
   function automatic logic [3:0] mbp_mod_palette(input logic [7:0] value);
      logic [4:0] sum;
      sum = {1'b0, value[7:4]} + {1'b0, value[3:0]};
      if (sum >= 5'(PaletteSize)) begin
         sum = sum - 5'(PaletteSize);
      end
      if (sum >= 5'(PaletteSize)) begin
         sum = sum - 5'(PaletteSize);
      end
      return sum[3:0];
   endfunction

endpackage

// ----- hdl/mbp_map.sv -----
module mbp_map #(
   parameter int LINE_WIDTH    = 640,
   parameter int LINE_COUNT    = 480,
   parameter int FRACTION_BITS = 10,
   parameter int ZW            = 20,
   parameter int CW            = 4,
   parameter int MAX_ITER      = 15
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             req_valid,
   input  logic [9:0]                       pixel_x,
   input  logic [8:0]                       pixel_y,
   output mbp_pkg::mbp_ctl_type             ctl_o,
   output logic signed [ZW-1:0]             zr_o,
   output logic signed [ZW-1:0]             zi_o,
   output logic signed [ZW-1:0]             cr_o,
   output logic signed [ZW-1:0]             ci_o,
   output logic [CW-1:0]                    count_o,
   output logic [mbp_pkg::AddrWidth-1:0]    addr_o
);
   import mbp_pkg::*;

   localparam int FixOne = 1 << FRACTION_BITS;
   localparam int StepXInt = (4 * FixOne) / LINE_WIDTH;
   localparam int StepYInt = (4 * FixOne) / LINE_COUNT;
   localparam logic [ZW-1:0] StepX = ZW'(StepXInt);
   localparam logic [ZW-1:0] StepY = ZW'(StepYInt);
   localparam logic [ZW-1:0] TwoOne = ZW'(2 * FixOne);
   localparam logic [AddrWidth-1:0] LineStride = AddrWidth'(LINE_WIDTH);

   mbp_ctl_type          ctl_ff, ctl_in;
   logic [ZW-1:0]        cr_in, ci_in;
   logic signed [ZW-1:0] cr_ff, ci_ff;
   logic [AddrWidth-1:0] addr_ff, addr_in;

   // Map the pixel to the complex plane and form its linear address.
   always_comb begin
      ctl_in.valid = req_valid;
      ctl_in.done  = 1'b0;
      cr_in   = ZW'(pixel_x) * StepX - TwoOne;
      ci_in   = ZW'(pixel_y) * StepY - TwoOne;
      addr_in = AddrWidth'(pixel_x) + AddrWidth'(pixel_y) * LineStride;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cr_ff   <= $signed(cr_in);
         ci_ff   <= $signed(ci_in);
         addr_ff <= addr_in;
      end
   end

   // Z starts at C and the count at its maximum.
   assign ctl_o   = ctl_ff;
   assign zr_o    = cr_ff;
   assign zi_o    = ci_ff;
   assign cr_o    = cr_ff;
   assign ci_o    = ci_ff;
   assign count_o = CW'(MAX_ITER);
   assign addr_o  = addr_ff;

endmodule

// ----- hdl/mbp_cell.sv -----
module mbp_cell #(
   parameter int FRACTION_BITS = 10,
   parameter int ZW            = 20,
   parameter int CW            = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  mbp_pkg::mbp_ctl_type             ctl_i,
   input  logic signed [ZW-1:0]             zr_i,
   input  logic signed [ZW-1:0]             zi_i,
   input  logic signed [ZW-1:0]             cr_i,
   input  logic signed [ZW-1:0]             ci_i,
   input  logic [CW-1:0]                    count_i,
   input  logic [mbp_pkg::AddrWidth-1:0]    addr_i,
   output mbp_pkg::mbp_ctl_type             ctl_o,
   output logic signed [ZW-1:0]             zr_o,
   output logic signed [ZW-1:0]             zi_o,
   output logic signed [ZW-1:0]             cr_o,
   output logic signed [ZW-1:0]             ci_o,
   output logic [CW-1:0]                    count_o,
   output logic [mbp_pkg::AddrWidth-1:0]    addr_o
);
   import mbp_pkg::*;

   localparam int PW = 2 * ZW;
   localparam logic signed [PW-1:0] EscLimit = PW'(4 << FRACTION_BITS);

   logic signed [PW-1:0] prod_rr, prod_ii, prod_ri;
   logic signed [PW-1:0] zr2, zi2, zri, mag, zr_sum, zi_sum;
   logic                 escape;

   mbp_ctl_type          ctl_ff, ctl_in;
   logic signed [ZW-1:0] zr_ff, zr_in, zi_ff, zi_in, cr_ff, ci_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic [AddrWidth-1:0] addr_ff;

   // One iteration step: square, test the magnitude, update Z and count down.
   always_comb begin
      prod_rr = zr_i * zr_i;
      prod_ii = zi_i * zi_i;
      prod_ri = zr_i * zi_i;
      zr2     = prod_rr >>> FRACTION_BITS;
      zi2     = prod_ii >>> FRACTION_BITS;
      zri     = prod_ri >>> (FRACTION_BITS - 1);
      mag     = zr2 + zi2;
      escape  = mag > EscLimit;
      zr_sum  = zr2 - zi2 + PW'(cr_i);
      zi_sum  = zri + PW'(ci_i);

      ctl_in   = ctl_i;
      zr_in    = zr_i;
      zi_in    = zi_i;
      count_in = count_i;
      // An item that already escaped passes through untouched.
      if (ctl_i.valid && !ctl_i.done) begin
         if (escape) begin
            ctl_in.done = 1'b1;
         end else begin
            zr_in    = zr_sum[ZW-1:0];
            zi_in    = zi_sum[ZW-1:0];
            count_in = count_i - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zr_ff    <= zr_in;
         zi_ff    <= zi_in;
         cr_ff    <= cr_i;
         ci_ff    <= ci_i;
         count_ff <= count_in;
         addr_ff  <= addr_i;
      end
   end

   assign ctl_o   = ctl_ff;
   assign zr_o    = zr_ff;
   assign zi_o    = zi_ff;
   assign cr_o    = cr_ff;
   assign ci_o    = ci_ff;
   assign count_o = count_ff;
   assign addr_o  = addr_ff;

endmodule

// ----- hdl/mandelbrot_pixel_iterator.sv -----
// Mandelbrot pixel iterator.
// The req_ channel takes one pixel coordinate per item (req_pixel_x, req_pixel_y);
// the rsp_ channel returns one item per pixel: its frame buffer address, its
// color and the iteration count left at escape (0 means it never escaped).
// Both channels use valid/ready. Items come out in the order they went in.
// Colors are set through the csr_ write port: index 0 picks palette coloring,
// index 1 sets the left shift of the count in shifted coloring. Write them
// only while no item is in flight.
// Internally a mapping stage feeds a chain of MAX_ITERATIONS identical cells,
// each doing one iteration with three multipliers; an output register follows.
// Each accepted item passes the mapping register, every cell register and the output
// register; a new item is accepted every cycle while the output is empty or drained.
// When the receiver stalls with a result held, the whole chain freezes and
// req_ready drops until that result is taken.
// Synchronous reset empties the chain and sets palette coloring off and the
// shift to one.
module mandelbrot_pixel_iterator #(
   parameter int LINE_WIDTH     = 640,
   parameter int LINE_COUNT     = 480,
   parameter int MAX_ITERATIONS = 15,
   parameter int FRACTION_BITS  = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [9:0]                             req_pixel_x,
   input  logic [8:0]                             req_pixel_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [mbp_pkg::AddrWidth-1:0]          rsp_pixel_address,
   output logic [mbp_pkg::ColorWidth-1:0]         rsp_pixel_color,
   output logic [mbp_pkg::CountOutWidth-1:0]      rsp_count_left,
   input  logic                                   csr_we,
   input  mbp_pkg::csr_index_type                 csr_index,
   input  logic [mbp_pkg::CsrDataWidth-1:0]       csr_wdata
);
   import mbp_pkg::*;

   `include "mandelbrot_pixel_iterator_assert.svh"

   localparam int ZW = FRACTION_BITS + 10;
   localparam int CW = $clog2(MAX_ITERATIONS + 1);

   logic advance;

   mbp_ctl_type          ctl_chain   [MAX_ITERATIONS+1];
   logic signed [ZW-1:0] zr_chain    [MAX_ITERATIONS+1];
   logic signed [ZW-1:0] zi_chain    [MAX_ITERATIONS+1];
   logic signed [ZW-1:0] cr_chain    [MAX_ITERATIONS+1];
   logic signed [ZW-1:0] ci_chain    [MAX_ITERATIONS+1];
   logic [CW-1:0]        count_chain [MAX_ITERATIONS+1];
   logic [AddrWidth-1:0] addr_chain  [MAX_ITERATIONS+1];

   logic                  indexed_ff;
   logic [CsrDataWidth-1:0] shift_ff;

   logic                      out_valid_ff;
   logic [AddrWidth-1:0]      out_addr_ff;
   logic [ColorWidth-1:0]     out_color_ff, color_in;
   logic [CountOutWidth-1:0]  out_count_ff;
   logic [CW-1:0]             last_count;

   // The chain moves whenever the output register is empty or being drained.
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         indexed_ff <= 1'b0;
         shift_ff   <= CsrDataWidth'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_INDEXED_COLORS: indexed_ff <= csr_wdata[0];
            CSR_COLOR_SHIFT:    shift_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Coordinate mapping stage at the head of the chain.
   mbp_map #(
      .LINE_WIDTH(LINE_WIDTH),
      .LINE_COUNT(LINE_COUNT),
      .FRACTION_BITS(FRACTION_BITS),
      .ZW(ZW),
      .CW(CW),
      .MAX_ITER(MAX_ITERATIONS)
   ) u_map (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .req_valid(req_valid),
      .pixel_x(req_pixel_x),
      .pixel_y(req_pixel_y),
      .ctl_o(ctl_chain[0]),
      .zr_o(zr_chain[0]),
      .zi_o(zi_chain[0]),
      .cr_o(cr_chain[0]),
      .ci_o(ci_chain[0]),
      .count_o(count_chain[0]),
      .addr_o(addr_chain[0])
   );

   // One cell per iteration.
   for (genvar k = 0; k < MAX_ITERATIONS; k++) begin : g_cell
      mbp_cell #(
         .FRACTION_BITS(FRACTION_BITS),
         .ZW(ZW),
         .CW(CW)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .advance(advance),
         .ctl_i(ctl_chain[k]),
         .zr_i(zr_chain[k]),
         .zi_i(zi_chain[k]),
         .cr_i(cr_chain[k]),
         .ci_i(ci_chain[k]),
         .count_i(count_chain[k]),
         .addr_i(addr_chain[k]),
         .ctl_o(ctl_chain[k+1]),
         .zr_o(zr_chain[k+1]),
         .zi_o(zi_chain[k+1]),
         .cr_o(cr_chain[k+1]),
         .ci_o(ci_chain[k+1]),
         .count_o(count_chain[k+1]),
         .addr_o(addr_chain[k+1])
      );
   end

   assign last_count = count_chain[MAX_ITERATIONS];

   // Color from the final count, in palette or shifted form.
   always_comb begin
      if (indexed_ff) begin
         if (last_count == '0) begin
            color_in = '0;
         end else begin
            color_in = ColorWidth'(mbp_mod_palette(8'(last_count))) + ColorWidth'(1);
         end
      end else begin
         color_in = (ColorWidth'(last_count) << shift_ff)
                  | ColorWidth'(last_count == '0);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= ctl_chain[MAX_ITERATIONS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_addr_ff  <= addr_chain[MAX_ITERATIONS];
         out_color_ff <= color_in;
         out_count_ff <= CountOutWidth'(last_count);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_address = out_addr_ff;
   assign rsp_pixel_color   = out_color_ff;
   assign rsp_count_left    = out_count_ff;

   // An item that never escaped has used up every iteration.
   `MPI_ASSERT_SAME(a_full_run_ends_at_zero, clock, reset,
      ctl_chain[MAX_ITERATIONS].valid && !ctl_chain[MAX_ITERATIONS].done,
      last_count == '0)
   // An escape always happens with iterations still left.
   `MPI_ASSERT_SAME(a_escape_leaves_count, clock, reset,
      ctl_chain[MAX_ITERATIONS].valid && ctl_chain[MAX_ITERATIONS].done,
      last_count != '0)
   // A stalled output freezes the chain, including the head stage.
   `MPI_ASSERT_NEXT(a_stall_freezes_chain, clock, reset,
      !advance,
      $stable(ctl_chain[0]) && $stable(ctl_chain[MAX_ITERATIONS]))

endmodule
